[hw/rtl/quoted_token_scanner_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quoted token scanner
// Clocked, reset-qualified property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_SCANNER_UNIT_MACROS_SVH
`define QUOTED_TOKEN_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quoted token scanner check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define QTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quoted token scanner check failed");

`endif

[hw/rtl/qts_pkg.sv]
// ----------------------------------------------------------------------------
// qts_pkg
// Types, character codes and defaults shared by the quoted token scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned TOKEN_COUNT_W  = 20;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned LINE_W         = 32;
  localparam int unsigned ERR_W          = 2;
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF  = 20;
  localparam logic [TOKEN_COUNT_W-1:0] TOKEN_COUNT_RST = TOKEN_COUNT_W'(1);

  localparam logic [BYTE_W-1:0] CH_HASH      = 8'h23;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LT        = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT        = 8'h3E;

  typedef enum logic [1:0] {
    MODE_WS      = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_BARE    = 2'd2,
    MODE_QUOTED  = 2'd3
  } scan_mode_e;

  typedef enum logic [1:0] {
    NP_IDLE = 2'd0,
    NP_LT   = 2'd1,
    NP_NULL = 2'd2,
    NP_NOT  = 2'd3
  } null_prefix_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE          = 2'd0,
    ERR_OPEN_COMMENT  = 2'd1,
    ERR_OPEN_QUOTE    = 2'd2,
    ERR_MISSING_VALUE = 2'd3
  } error_code_e;

  typedef enum logic {
    KIND_TOKEN = 1'b0,
    KIND_ERROR = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  token_start;
    logic [POS_W-1:0]  token_end;
    logic              null_marker;
    error_code_e       error_code;
    logic [LINE_W-1:0] src_line;
    logic              last;
  } qts_result_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/qts_if.sv]
// ----------------------------------------------------------------------------
// qts_in_if / qts_out_if
// Valid/ready channels for byte items in and scan results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qts_in_if
  import qts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface qts_out_if
  import qts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [POS_W-1:0]  token_start;
  logic [POS_W-1:0]  token_end;
  logic              null_marker;
  logic [ERR_W-1:0]  error_code;
  logic [LINE_W-1:0] src_line;
  logic              last;

  modport source (output valid, output kind, output token_start, output token_end,
                  output null_marker, output error_code, output src_line,
                  output last, input ready);
  modport sink   (input valid, input kind, input token_start, input token_end,
                  input null_marker, input error_code, input src_line,
                  input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/qts_scan_core.sv]
// ----------------------------------------------------------------------------
// qts_scan_core
// Per-byte mode machine, offset/line/token counters and result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qts_scan_core
  import qts_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [TOKEN_COUNT_W-1:0] cfg_wdata_i,
  input  wire logic                     accept_i,
  input  wire logic [BYTE_W-1:0]        in_byte_i,
  input  wire logic                     end_of_input_i,
  output logic                          push_o,
  output qts_result_t                   res_o
);

  logic [TOKEN_COUNT_W-1:0] token_count_q;
  scan_mode_e               mode_q, mode_d;
  logic [OFFSET_BITS-1:0]   offset_q, offset_d;
  logic [OFFSET_BITS-1:0]   tok_start_q, tok_start_d;
  logic [LINE_W-1:0]        line_q, line_d;
  logic                     bslash_q, bslash_d;
  null_prefix_e             np_q, np_d;
  logic [COUNT_BITS-1:0]    found_q, found_d;
  logic                     finished_q, finished_d;

  logic [COUNT_BITS-1:0]    found_inc;
  logic                     is_last;
  logic [OFFSET_BITS-1:0]   offset_inc;

  assign found_inc  = found_q + COUNT_BITS'(1);
  assign is_last    = (found_inc == COUNT_BITS'(token_count_q));
  assign offset_inc = offset_q + OFFSET_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_count_q <= TOKEN_COUNT_RST;
    end else if (cfg_we_i) begin
      token_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_WS;
      offset_q    <= '0;
      tok_start_q <= '0;
      line_q      <= LINE_W'(1);
      bslash_q    <= 1'b0;
      np_q        <= NP_IDLE;
      found_q     <= '0;
      finished_q  <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      offset_q    <= offset_d;
      tok_start_q <= tok_start_d;
      line_q      <= line_d;
      bslash_q    <= bslash_d;
      np_q        <= np_d;
      found_q     <= found_d;
      finished_q  <= finished_d;
    end
  end

  always_comb begin
    mode_d      = mode_q;
    offset_d    = offset_q;
    tok_start_d = tok_start_q;
    line_d      = line_q;
    bslash_d    = bslash_q;
    np_d        = np_q;
    found_d     = found_q;
    finished_d  = finished_q;
    push_o      = 1'b0;

    // Line number reflects the count before this byte's own update.
    res_o             = '0;
    res_o.kind        = KIND_TOKEN;
    res_o.error_code  = ERR_NONE;
    res_o.src_line    = line_q;

    if (accept_i && !finished_q) begin
      if (end_of_input_i) begin
        push_o     = 1'b1;
        finished_d = 1'b1;
        res_o.kind = KIND_ERROR;
        res_o.last = 1'b1;
        unique case (mode_q)
          MODE_COMMENT: res_o.error_code = ERR_OPEN_COMMENT;
          MODE_QUOTED:  res_o.error_code = ERR_OPEN_QUOTE;
          MODE_BARE: begin
            if (is_last) begin
              // A bare token cut by end of input closes only if it is the final one.
              res_o.kind        = KIND_TOKEN;
              res_o.token_start = POS_W'(tok_start_q);
              res_o.token_end   = POS_W'(offset_q);
              res_o.null_marker = (np_q == NP_NULL);
              found_d           = found_inc;
              mode_d            = MODE_WS;
            end else begin
              res_o.error_code = ERR_MISSING_VALUE;
            end
          end
          MODE_WS:      res_o.error_code = ERR_MISSING_VALUE;
        endcase
      end else begin
        offset_d = offset_inc;
        unique case (mode_q)
          MODE_WS: begin
            priority if (in_byte_i == CH_LF) begin
              line_d = line_q + LINE_W'(1);
            end else if (in_byte_i == CH_HASH) begin
              mode_d = MODE_COMMENT;
            end else if (!is_space(in_byte_i)) begin
              tok_start_d = offset_q;
              bslash_d    = 1'b0;
              if (in_byte_i == CH_QUOTE) begin
                mode_d = MODE_QUOTED;
                np_d   = NP_NOT;
              end else begin
                mode_d = MODE_BARE;
                np_d   = (in_byte_i == CH_LT) ? NP_LT : NP_NOT;
              end
            end else begin
              mode_d = MODE_WS;
            end
          end
          MODE_COMMENT: begin
            if (in_byte_i == CH_HASH) begin
              mode_d = MODE_WS;
            end else if (in_byte_i == CH_LF) begin
              line_d = line_q + LINE_W'(1);
            end
          end
          MODE_BARE: begin
            if (is_space(in_byte_i)) begin
              push_o            = 1'b1;
              res_o.token_start = POS_W'(tok_start_q);
              res_o.token_end   = POS_W'(offset_q);
              res_o.null_marker = (np_q == NP_NULL);
              res_o.last        = is_last;
              found_d           = found_inc;
              finished_d        = is_last;
              mode_d            = MODE_WS;
              if (in_byte_i == CH_LF) begin
                line_d = line_q + LINE_W'(1);
              end
            end else if (np_q == NP_LT) begin
              np_d = (in_byte_i == CH_GT) ? NP_NULL : NP_NOT;
            end
          end
          MODE_QUOTED: begin
            if ((in_byte_i == CH_QUOTE) && !bslash_q) begin
              push_o            = 1'b1;
              res_o.token_start = POS_W'(tok_start_q);
              res_o.token_end   = POS_W'(offset_inc);
              res_o.last        = is_last;
              found_d           = found_inc;
              finished_d        = is_last;
              mode_d            = MODE_WS;
            end else begin
              bslash_d = (in_byte_i == CH_BACKSLASH);
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qts_out_skid.sv]
// ----------------------------------------------------------------------------
// qts_out_skid
// Output register plus one skid entry, so input can keep flowing while a
// result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qts_out_skid
  import qts_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire qts_result_t  res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output qts_result_t       out_res_o
);

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  qts_result_t out_res_q, out_res_d;
  qts_result_t skid_res_q, skid_res_d;
  logic        pop;

  assign pop         = out_valid_q && out_ready_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    skid_res_d   = skid_res_q;
    if (skid_valid_q) begin
      // Input is held off while the skid entry is occupied.
      if (pop) begin
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_res_d   = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_res_d   = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

endmodule

`default_nettype wire

[hw/rtl/quoted_token_scanner_unit.sv]
// A result is registered in the output register, or in the skid entry when that register is busy.
// Throughput: one item per cycle while in_i.ready is high; the mode machine and counters update in one step.
// in_i.ready drops only while both the output register and its skid entry hold results.
// Reset (rst_ni low, asynchronous): skip-whitespace mode, offset 0, line 1, no tokens,
// token_count 1, output empty.
// ----------------------------------------------------------------------------
// quoted_token_scanner_unit
// Whitespace tokenizer with comments, quoted tokens and null-marker detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_token_scanner_unit_macros.svh"

module quoted_token_scanner_unit
  import qts_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [TOKEN_COUNT_W-1:0] cfg_wdata_i,
  qts_in_if.sink                        in_i,
  qts_out_if.source                     out_o
);

  logic        accept;
  logic        core_push;
  qts_result_t core_res;
  logic        skid_full;
  qts_result_t out_res;

  // Take a new item whenever the skid entry is free; a waiting result
  // in the output register does not stall the input.
  assign in_i.ready = !skid_full;
  assign accept     = in_i.valid && in_i.ready;

  // Scan state: mode, byte offset, token start, line count, escape flag,
  // null-marker tracker, token count and the finished flag.
  qts_scan_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .in_byte_i      (in_i.in_byte),
    .end_of_input_i (in_i.end_of_input),
    .push_o         (core_push),
    .res_o          (core_res)
  );

  // Result register with one skid entry behind it.
  qts_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (core_push),
    .res_i       (core_res),
    .full_o      (skid_full),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res)
  );

  // Drive the result channel fields.
  assign out_o.kind        = out_res.kind;
  assign out_o.token_start = out_res.token_start;
  assign out_o.token_end   = out_res.token_end;
  assign out_o.null_marker = out_res.null_marker;
  assign out_o.error_code  = out_res.error_code;
  assign out_o.src_line    = out_res.src_line;
  assign out_o.last        = out_res.last;

  // Errors always close the stream and carry no token position.
  `QTS_ASSERT_NOW(a_err_is_last, clk_i, rst_ni,
                  out_o.valid && (out_o.kind == KIND_ERROR), out_o.last)
  `QTS_ASSERT_NOW(a_err_no_pos, clk_i, rst_ni,
                  out_o.valid && (out_o.kind == KIND_ERROR),
                  (out_o.token_start == '0) && (out_o.token_end == '0) && !out_o.null_marker)
  `QTS_ASSERT_NOW(a_tok_no_err, clk_i, rst_ni,
                  out_o.valid && (out_o.kind == KIND_TOKEN), out_o.error_code == ERR_NONE)
  // Nothing follows a final result until reset.
  `QTS_ASSERT_NEXT(a_silent_after_last, clk_i, rst_ni, core_push && core_res.last, !core_push)

endmodule

`default_nettype wire
